[rtl/rpn_pkg.sv]
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types, codes and helpers for the RPN stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

  // token kinds
  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_OPER = 2'd1;
  localparam logic [1:0] MODE_END  = 2'd2;

  // operators
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_DIVZERO   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_LEFTOVER  = 3'd4;

  typedef struct packed {
    logic [1:0]         mode;
    logic [1:0]         opcode;
    logic signed [31:0] number;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] result_value;
  } out_t;

  // controller -> datapath commands
  typedef struct packed {
    logic push_num;   // write token number on top
    logic full_err;   // push onto full stack
    logic uf0;        // operator on empty stack
    logic uf1;        // operator with one entry
    logic latch_op;   // capture opcode
    logic rd_top;     // read entry depth-1
    logic rd_second;  // capture right operand, read entry depth-2
    logic rd_base;    // read entry 0
    logic exec;       // capture left operand and run operator
    logic mul_wr;     // write saturated product
    logic div_step;   // one divider iteration
    logic div_wr;     // write saturated quotient
    logic end_now;    // report from error/depth, clear
    logic end_read;   // report entry 0, clear
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic       depth_zero;
    logic       depth_one;
    logic       full;
    logic       err_none;
    logic       r_zero;
    logic       div_last;
    logic       out_busy;
    logic [1:0] op;
  } sts_t;

  // apply sign to a magnitude and saturate to signed 32 bits
  function automatic logic [31:0] sat_mag(input logic [63:0] m, input logic neg);
    logic [63:0] nm;
    nm = ~m + 64'd1;
    if (neg) begin
      if (m > 64'h0000_0000_8000_0000) return 32'h8000_0000;
      return nm[31:0];
    end
    if (m > 64'h0000_0000_7FFF_FFFF) return 32'h7FFF_FFFF;
    return m[31:0];
  endfunction

  // magnitude of a signed 32-bit value
  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

`default_nettype wire

[rtl/rpn_stack_evaluator.sv]
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Reverse Polish evaluator over pre-parsed Q16.16 tokens with a bounded stack.
// ----------------------------------------------------------------------------
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_stall    rpn_pkg::in_t  (mode, opcode, number)
//   out_     out  out_valid/out_stall  rpn_pkg::out_t (status, result_value)
//
// Push, ignored and end tokens are handled on acceptance (an end with a single entry first reads entry 0 in S_END).
// Add/subtract step through S_RDL and S_EXEC, multiply adds S_MUL; divide runs a restoring
// divider in S_DIV, one quotient bit a cycle, over the 32 + FRAC_BITS dividend bits.
// Reset (rst_n low, synchronous) empties the stack and clears the error.
// Input is stalled while an operator or an end read is in progress; an end
// token is also held off while a previous result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire rpn_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output rpn_pkg::out_t      out_data
);
  import rpn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rpn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rpn_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_opcode (in_data.opcode),
    .in_number (in_data.number),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[rtl/rpn_ctrl.sv]
// ----------------------------------------------------------------------------
// rpn_ctrl
// Token sequencer: decodes accepted tokens and steps the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_mode,
  output logic               in_stall,
  input  wire rpn_pkg::sts_t sts,
  output rpn_pkg::cmd_t      cmd
);
  import rpn_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RDL  = 6'b000010,
    S_EXEC = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_END  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // end tokens wait until the result register can take them
  assign in_stall = (state_r != S_IDLE) || ((in_mode == MODE_END) && sts.out_busy);
  assign accept   = in_valid && !in_stall;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_PUSH: begin
              if (sts.err_none) begin
                if (sts.full) cmd.full_err = 1'b1;
                else          cmd.push_num = 1'b1;
              end
            end
            MODE_OPER: begin
              if (sts.err_none) begin
                cmd.latch_op = 1'b1;
                if (sts.depth_zero)     cmd.uf0 = 1'b1;
                else if (sts.depth_one) cmd.uf1 = 1'b1;
                else begin
                  cmd.rd_top = 1'b1;
                  state_nxt  = S_RDL;
                end
              end
            end
            MODE_END: begin
              if (sts.err_none && sts.depth_one) begin
                cmd.rd_base = 1'b1;
                state_nxt   = S_END;
              end else begin
                cmd.end_now = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_RDL: begin
        cmd.rd_second = 1'b1;
        state_nxt     = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.op)
          OP_MUL:  state_nxt = S_MUL;
          OP_DIV:  state_nxt = sts.r_zero ? S_IDLE : S_DIV;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_MUL: begin
        cmd.mul_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_DIV: begin
        if (sts.div_last) begin
          cmd.div_wr = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_END: begin
        cmd.end_read = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

[rtl/rpn_dpath.sv]
// ----------------------------------------------------------------------------
// rpn_dpath
// Stack memory, depth/error registers, add/sub/mul unit, serial divider and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_dpath #(
  parameter int STACK_DEPTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [1:0]         in_opcode,
  input  wire logic signed [31:0] in_number,
  input  wire rpn_pkg::cmd_t      cmd,
  output rpn_pkg::sts_t           sts,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rpn_pkg::out_t           out_data
);
  import rpn_pkg::*;

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int NB = 32 + FRAC_BITS;          // divider dividend width
  localparam int CW = $clog2(NB + 1);

  logic [31:0]   mem [STACK_DEPTH];
  logic [31:0]   rd_q;
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [31:0]   wd;

  logic [DW-1:0] depth_r, depth_nxt, dm1, dm2;
  logic [2:0]    err_r, err_nxt;
  logic [1:0]    op_r;
  logic [31:0]   rop_r;
  logic          neg_r;
  logic [63:0]   prod_r;
  logic [NB-1:0] qd_r;
  logic [31:0]   rem_r;
  logic [32:0]   rem_sh, rem_sub;
  logic [31:0]   dv_r;
  logic [CW-1:0] cnt_r;
  logic          out_valid_r;
  out_t          out_r;

  logic [32:0]   sum;
  logic [31:0]   as_res;
  logic [31:0]   lmag, rmag;

  assign dm1 = depth_r - DW'(1);
  assign dm2 = depth_r - DW'(2);

  // add/subtract with saturation
  always_comb begin
    if (op_r == OP_SUB) sum = {rd_q[31], rd_q} - {rop_r[31], rop_r};
    else                sum = {rd_q[31], rd_q} + {rop_r[31], rop_r};
    if (sum[32] != sum[31]) as_res = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else                    as_res = sum[31:0];
  end

  assign lmag = mag32(rd_q);
  assign rmag = mag32(rop_r);

  // divider step; partial remainder stays below the divisor
  assign rem_sh  = {rem_r, qd_r[NB-1]};
  assign rem_sub = rem_sh - {1'b0, dv_r};

  // memory write port
  always_comb begin
    we = 1'b0;
    wa = depth_r[AW-1:0];
    wd = in_number;
    if (cmd.push_num) begin
      we = 1'b1;
    end else if (cmd.exec && (op_r == OP_ADD || op_r == OP_SUB)) begin
      we = 1'b1; wa = dm2[AW-1:0]; wd = as_res;
    end else if (cmd.mul_wr) begin
      we = 1'b1; wa = dm2[AW-1:0];
      wd = sat_mag(64'(prod_r >> FRAC_BITS), neg_r);
    end else if (cmd.div_wr) begin
      we = 1'b1; wa = dm2[AW-1:0];
      wd = sat_mag(64'(qd_r), neg_r);
    end
  end

  // memory read address
  always_comb begin
    ra = dm1[AW-1:0];
    if (cmd.rd_second)    ra = dm2[AW-1:0];
    else if (cmd.rd_base) ra = '0;
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  // depth and error
  always_comb begin
    depth_nxt = depth_r;
    err_nxt   = err_r;
    if (cmd.push_num) depth_nxt = depth_r + DW'(1);
    if (cmd.full_err) err_nxt = ST_FULL;
    if (cmd.uf0) err_nxt = ST_UNDERFLOW;
    if (cmd.uf1) begin
      err_nxt   = ST_UNDERFLOW;
      depth_nxt = '0;
    end
    if (cmd.exec && (op_r == OP_ADD || op_r == OP_SUB)) depth_nxt = dm1;
    if (cmd.exec && op_r == OP_DIV && rop_r == '0) begin
      err_nxt   = ST_DIVZERO;
      depth_nxt = dm2;
    end
    if (cmd.mul_wr || cmd.div_wr) depth_nxt = dm1;
    if (cmd.end_now || cmd.end_read) begin
      depth_nxt = '0;
      err_nxt   = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      err_r   <= ST_OK;
    end else begin
      depth_r <= depth_nxt;
      err_r   <= err_nxt;
    end
  end

  // operand, multiplier and divider registers
  always_ff @(posedge clk) begin
    if (cmd.latch_op)  op_r  <= in_opcode;
    if (cmd.rd_second) rop_r <= rd_q;
    if (cmd.exec) begin
      neg_r  <= rd_q[31] ^ rop_r[31];
      prod_r <= 64'(lmag) * 64'(rmag);
      qd_r   <= NB'(lmag) << FRAC_BITS;
      rem_r  <= '0;
      dv_r   <= rmag;
    end else if (cmd.div_step) begin
      if (!rem_sub[32]) rem_r <= rem_sub[31:0];
      else              rem_r <= rem_sh[31:0];
      qd_r <= {qd_r[NB-2:0], ~rem_sub[32]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)                 cnt_r <= '0;
    else if (cmd.exec)          cnt_r <= CW'(NB);
    else if (cmd.div_step)      cnt_r <= cnt_r - CW'(1);
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.end_now || cmd.end_read) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.end_now) begin
      out_r.result_value <= '0;
      if (err_r != ST_OK)       out_r.status <= err_r;
      else if (depth_r == '0)   out_r.status <= ST_UNDERFLOW;
      else                      out_r.status <= ST_LEFTOVER;
    end else if (cmd.end_read) begin
      out_r.status       <= ST_OK;
      out_r.result_value <= rd_q;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // status to controller
  always_comb begin
    sts            = '0;
    sts.depth_zero = (depth_r == '0);
    sts.depth_one  = (depth_r == DW'(1));
    sts.full       = (depth_r >= DW'(STACK_DEPTH));
    sts.err_none   = (err_r == ST_OK);
    sts.r_zero     = (rop_r == '0);
    sts.div_last   = (cnt_r == '0);
    sts.out_busy   = out_valid_r && out_stall;
    sts.op         = op_r;
  end

  // checks
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(STACK_DEPTH)) else $error("stack depth out of range");
  a_val_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != ST_OK |-> out_r.result_value == '0)
    else $error("nonzero value with error status");
  a_no_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_num |-> depth_r < DW'(STACK_DEPTH)) else $error("push onto full stack");
  a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.end_now || cmd.end_read |=> depth_r == '0 && err_r == ST_OK)
    else $error("end token did not clear state");

endmodule

`default_nettype wire

[tb/rpn_checker.sv]
// ----------------------------------------------------------------------------
// rpn_checker
// Watches both channels of the RPN evaluator, keeps its own model of the stack
// and compares every reported status and value with the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_checker
  import rpn_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_stall,
  input  in_t   in_data,
  input  logic  out_valid,
  input  logic  out_stall,
  input  out_t  out_data,
  output int    fail_count,
  output int    pending_reports,
  output int    reports_seen
);

  localparam int DEPTH = 16;
  localparam int FRAC  = 16;

  logic signed [31:0] stk [DEPTH];
  int                 stk_depth;
  logic [2:0]         expr_err;
  out_t               report_q [$];

  function automatic logic signed [31:0] clamp_val(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] signed_clamp(input logic [63:0] m, input logic neg);
    if (neg) return clamp_val(-$signed({1'b0, m[62:0]}) - (m[63] ? 64'sd0 : 64'sd0));
    return clamp_val($signed({1'b0, m[62:0]}));
  endfunction

  function automatic logic [63:0] abs_val(input logic signed [31:0] v);
    logic signed [63:0] w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  // apply one operator to the model; returns new error code
  function automatic logic [2:0] apply_operator(input logic [1:0] op);
    logic signed [31:0] r, l, res;
    logic               neg;
    logic [63:0]        m;
    if (stk_depth == 0) return ST_UNDERFLOW;
    stk_depth--;
    r = stk[stk_depth];
    if (stk_depth == 0) return ST_UNDERFLOW;
    stk_depth--;
    l = stk[stk_depth];
    neg = l[31] ^ r[31];
    case (op)
      OP_ADD: res = clamp_val(64'(l) + 64'(r));
      OP_SUB: res = clamp_val(64'(l) - 64'(r));
      OP_MUL: begin
        m = (abs_val(l) * abs_val(r)) >> FRAC;
        res = signed_clamp(m, neg);
      end
      default: begin
        if (r == 0) return ST_DIVZERO;
        m = (abs_val(l) << FRAC) / abs_val(r);
        res = signed_clamp(m, neg);
      end
    endcase
    stk[stk_depth] = res;
    stk_depth++;
    return ST_OK;
  endfunction

  // predict on each accepted input transfer
  always @(posedge clk) begin
    out_t exp_r;
    if (!rst_n) begin
      stk_depth = 0;
      expr_err  = ST_OK;
    end else if (in_valid && !in_stall) begin
      case (in_data.mode)
        MODE_PUSH: begin
          if (expr_err == ST_OK) begin
            if (stk_depth >= DEPTH) expr_err = ST_FULL;
            else begin
              stk[stk_depth] = in_data.number;
              stk_depth++;
            end
          end
        end
        MODE_OPER: begin
          if (expr_err == ST_OK) expr_err = apply_operator(in_data.opcode);
        end
        MODE_END: begin
          exp_r.status = expr_err;
          exp_r.result_value = '0;
          if (expr_err == ST_OK) begin
            if (stk_depth == 0) exp_r.status = ST_UNDERFLOW;
            else if (stk_depth != 1) exp_r.status = ST_LEFTOVER;
            else exp_r.result_value = stk[0];
          end
          report_q.push_back(exp_r);
          stk_depth = 0;
          expr_err  = ST_OK;
        end
        default: ;
      endcase
    end
  end

  // compare each accepted result transfer
  always @(posedge clk) begin
    out_t exp_r;
    if (!rst_n) begin
      fail_count   <= 0;
      reports_seen <= 0;
    end else if (out_valid && !out_stall) begin
      reports_seen <= reports_seen + 1;
      if (report_q.size() == 0) begin
        $error("unexpected result: status=%0d value=%0d",
               out_data.status, out_data.result_value);
        fail_count <= fail_count + 1;
      end else begin
        exp_r = report_q.pop_front();
        if (out_data.status !== exp_r.status || out_data.result_value !== exp_r.result_value)
          fail_count <= fail_count + 1;
        if (out_data.status !== exp_r.status)
          $error("status: expected %0d, got %0d", exp_r.status, out_data.status);
        if (out_data.result_value !== exp_r.result_value)
          $error("result_value: expected %0d, got %0d",
                 exp_r.result_value, out_data.result_value);
      end
    end
  end

  assign pending_reports = report_q.size();

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the RPN evaluator: directed corner expressions, then random
// well-formed expressions mixed with broken ones, under bursty traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rpn_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  int   fail_count, pending_reports, reports_seen;
  int   tokens_sent = 0;
  int   idle_cycles = 0;
  bit   long_hold = 1'b0;
  bit   stall_en = 1'b0;

  always #5 clk = ~clk;

  rpn_stack_evaluator u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data
  );

  rpn_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .fail_count, .pending_reports, .reports_seen
  );

  // receiver stall pattern, plus one long hold-off
  always @(posedge clk) begin
    if (long_hold) out_stall <= 1'b1;
    else if (!stall_en) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  int burst_left = 0;

  // one token transfer, with random gaps between bursts
  task automatic send_token(input logic [1:0] mode, input logic [1:0] op,
                            input logic [31:0] num);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{mode: mode, opcode: op, number: num};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tokens_sent++;
  endtask

  function automatic logic [31:0] rand_num();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom_range(0, 8) << 16;
      4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // well-formed expression of random shape
  task automatic send_expression();
    int depth_now, n;
    depth_now = 0;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      if (depth_now >= 2 && ($urandom_range(0, 1) == 1 || depth_now >= 15)) begin
        send_token(MODE_OPER, 2'($urandom_range(0, 3)), $urandom);
        depth_now--;
      end else begin
        send_token(MODE_PUSH, 2'($urandom), rand_num());
        depth_now++;
      end
    end
    while (depth_now > 1) begin
      send_token(MODE_OPER, 2'($urandom_range(0, 3)), $urandom);
      depth_now--;
    end
    send_token(MODE_END, 2'($urandom), $urandom);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: saturation, each operator, every error case
    send_token(MODE_PUSH, OP_ADD, 32'h7FFF_FFFF);
    send_token(MODE_PUSH, OP_ADD, 32'h7FFF_FFFF);
    send_token(MODE_OPER, OP_ADD, 32'h0);
    send_token(MODE_END, OP_ADD, 32'h0);
    send_token(MODE_PUSH, OP_ADD, 32'h8000_0000);
    send_token(MODE_PUSH, OP_ADD, 32'h7FFF_FFFF);
    send_token(MODE_OPER, OP_SUB, 32'h0);
    send_token(MODE_END, OP_SUB, 32'hFFFF_FFFF);
    send_token(MODE_PUSH, OP_MUL, 32'h8000_0000);
    send_token(MODE_PUSH, OP_MUL, 32'h8000_0000);
    send_token(MODE_OPER, OP_MUL, 32'h0);
    send_token(MODE_END, OP_MUL, 32'h0);
    send_token(MODE_PUSH, OP_DIV, 32'h8000_0000);
    send_token(MODE_PUSH, OP_DIV, 32'hFFFF_0000);
    send_token(MODE_OPER, OP_DIV, 32'h0);
    send_token(MODE_END, OP_DIV, 32'h0);
    send_token(MODE_PUSH, OP_DIV, 32'h0001_0000);
    send_token(MODE_PUSH, OP_DIV, 32'h0);
    send_token(MODE_OPER, OP_DIV, 32'h0);
    send_token(MODE_END, OP_DIV, 32'h0);
    send_token(MODE_END, OP_ADD, 32'h0);
    send_token(MODE_PUSH, OP_ADD, 32'h5);
    send_token(MODE_OPER, OP_SUB, 32'h0);
    send_token(2'd3, OP_ADD, 32'h1234);
    send_token(MODE_END, OP_ADD, 32'h0);
    for (int i = 0; i < 18; i++) send_token(MODE_PUSH, 2'(i), 32'(i));
    send_token(MODE_END, OP_ADD, 32'h0);
    send_token(MODE_PUSH, OP_ADD, 32'h1);
    send_token(MODE_PUSH, OP_ADD, 32'h2);
    send_token(MODE_END, OP_ADD, 32'h0);

    // long receiver hold-off while expressions keep coming
    long_hold = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      repeat (6) send_expression();
    join
    stall_en = 1'b1;

    // random: mostly well-formed, some noise tokens
    while (tokens_sent < 1950) begin
      if ($urandom_range(0, 4) != 0) send_expression();
      else send_token(2'($urandom), 2'($urandom), rand_num());
      if ($urandom_range(0, 20) == 0) stall_en = ~stall_en;
    end
    send_token(MODE_END, OP_ADD, 32'h0);
    in_valid <= 1'b0;

    while (pending_reports != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d tokens, checked %0d results (saturation, divide, errors, stalls)",
             tokens_sent, reports_seen);
    if (fail_count == 0 && pending_reports == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[rpn_stack_evaluator.f]
rtl/rpn_pkg.sv
rtl/rpn_ctrl.sv
rtl/rpn_dpath.sv
rtl/rpn_stack_evaluator.sv
tb/rpn_checker.sv
tb/tb.sv
